FILE: rtl/cvms_pkg.sv
// Shared types and constants for the closest video mode selector.
package cvms_pkg;

  localparam int MODE_W   = 16;
  localparam int RES_W    = 16;
  localparam int DEPTH_W  = 8;
  localparam int GAP_W    = 16;
  localparam int SQ_W     = 2 * RES_W;
  localparam int DIST_W   = SQ_W + 1;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [MODE_W-1:0]  ATTR_NEEDED  = 16'h0099;
  localparam logic [MODE_W-1:0]  LINEAR_BIT   = 16'h4000;
  localparam logic [DEPTH_W-1:0] MODEL_PACKED = 8'd4;
  localparam logic [DEPTH_W-1:0] MODEL_DIRECT = 8'd6;
  localparam logic [DIST_W-1:0]  DIST_ONES    = '1;
  localparam logic [GAP_W-1:0]   GAP_ONES     = '1;

  localparam logic [1:0] REG_TARGET_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TARGET_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TARGET_DEPTH  = 2'd2;

  typedef enum logic [1:0] {
    KIND_END,
    KIND_EXACT,
    KIND_CAND
  } kind_t;

  typedef struct packed {
    logic [RES_W-1:0]   width;
    logic [RES_W-1:0]   height;
    logic [DEPTH_W-1:0] depth;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [MODE_W-1:0] mode;
    logic [RES_W-1:0]  dx;
    logic [RES_W-1:0]  dy;
    logic [GAP_W-1:0]  gap;
  } entry_t;

endpackage

FILE: rtl/cvms_if.sv
// Valid/ready channel interfaces for mode descriptors and selection results.
interface cvms_in_if;
  logic        valid;
  logic        ready;
  logic        end_of_list;
  logic        info_ok;
  logic [15:0] mode_number;
  logic [15:0] mode_attributes;
  logic [7:0]  memory_model;
  logic [15:0] mode_width;
  logic [15:0] mode_height;
  logic [7:0]  mode_depth;

  modport source (output valid, end_of_list, info_ok, mode_number, mode_attributes,
                  memory_model, mode_width, mode_height, mode_depth, input ready);
  modport sink (input valid, end_of_list, info_ok, mode_number, mode_attributes,
                memory_model, mode_width, mode_height, mode_depth, output ready);
endinterface

interface cvms_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] chosen_mode;
  logic        exact_hit;

  modport source (output valid, chosen_mode, exact_hit, input ready);
  modport sink (input valid, chosen_mode, exact_hit, output ready);
endinterface

FILE: rtl/cvms_front.sv
// Front end: filters descriptors and turns each kept word into a queue entry.
module cvms_front (
  cvms_in_if.sink         in_chan,
  input  cvms_pkg::cfg_t  cfg,
  input  logic            q_full,
  output logic            q_push,
  output cvms_pkg::entry_t q_entry
);
  import cvms_pkg::*;

  logic usable;
  logic exact;
  logic fits;

  assign in_chan.ready = !q_full;

  always_comb begin
    usable = in_chan.info_ok
          && ((in_chan.mode_attributes & ATTR_NEEDED) == ATTR_NEEDED)
          && (in_chan.memory_model == MODEL_PACKED || in_chan.memory_model == MODEL_DIRECT);
    exact  = (in_chan.mode_width == cfg.width) && (in_chan.mode_height == cfg.height)
          && (in_chan.mode_depth == cfg.depth);
    fits   = (in_chan.mode_width <= cfg.width) && (in_chan.mode_height <= cfg.height);

    q_entry.mode   = in_chan.mode_number;
    q_entry.dx     = cfg.width - in_chan.mode_width;
    q_entry.dy     = cfg.height - in_chan.mode_height;
    q_entry.gap    = {{(GAP_W-DEPTH_W){1'b0}}, cfg.depth}
                   - {{(GAP_W-DEPTH_W){1'b0}}, in_chan.mode_depth};
    q_entry.kind   = KIND_CAND;
    q_push         = 1'b0;

    if (in_chan.valid && !q_full) begin
      if (in_chan.end_of_list) begin
        q_entry.kind = KIND_END;
        q_push       = 1'b1;
      end else if (usable && exact) begin
        q_entry.kind = KIND_EXACT;
        q_push       = 1'b1;
      end else if (usable && fits) begin
        q_push       = 1'b1;
      end
    end
  end

endmodule

FILE: rtl/cvms_queue.sv
// Short queue that decouples the classifying front end from the selection back end.
module cvms_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cvms_pkg::entry_t push_entry,
  input  logic             pop,
  output cvms_pkg::entry_t head,
  output logic             empty,
  output logic             full
);
  import cvms_pkg::*;

  entry_t              slots_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign head  = slots_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wptr_r] <= push_entry;
    end
  end

endmodule

FILE: rtl/cvms_back.sv
// Back end: squares the distances, keeps the running best and drives the result word.
module cvms_back (
  input  logic             clk,
  input  logic             rst_n,
  input  cvms_pkg::entry_t head,
  input  logic             q_empty,
  output logic             q_pop,
  cvms_out_if.source       out_chan
);
  import cvms_pkg::*;

  // Square stage.
  logic                s1_valid_r, s1_valid_nxt;
  kind_t               s1_kind_r;
  logic [MODE_W-1:0]   s1_mode_r;
  logic [SQ_W-1:0]     s1_sqx_r;
  logic [SQ_W-1:0]     s1_sqy_r;
  logic [GAP_W-1:0]    s1_gap_r;

  // Running best.
  logic [MODE_W-1:0]   best_mode_r, best_mode_nxt;
  logic [DIST_W-1:0]   best_dist_r, best_dist_nxt;
  logic [GAP_W-1:0]    best_gap_r, best_gap_nxt;
  logic                done_r, done_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [MODE_W-1:0]   out_mode_r, out_mode_nxt;
  logic                out_exact_r, out_exact_nxt;

  logic                out_free;
  logic                s1_emits;
  logic                s1_adv;
  logic [DIST_W-1:0]   cand_dist;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.chosen_mode = out_mode_r;
  assign out_chan.exact_hit   = out_exact_r;

  always_comb begin
    out_free  = !out_valid_r || out_chan.ready;
    s1_emits  = !done_r && (s1_kind_r == KIND_END || s1_kind_r == KIND_EXACT);
    s1_adv    = s1_valid_r && (!s1_emits || out_free);
    q_pop     = !q_empty && (!s1_valid_r || s1_adv);
    cand_dist = {1'b0, s1_sqx_r} + {1'b0, s1_sqy_r};

    s1_valid_nxt  = q_pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    best_mode_nxt = best_mode_r;
    best_dist_nxt = best_dist_r;
    best_gap_nxt  = best_gap_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_mode_nxt  = out_mode_r;
    out_exact_nxt = out_exact_r;

    if (s1_adv) begin
      case (s1_kind_r)
        KIND_END: begin
          if (!done_r) begin
            out_valid_nxt = 1'b1;
            out_mode_nxt  = (best_mode_r != '0) ? (best_mode_r | LINEAR_BIT) : '0;
            out_exact_nxt = 1'b0;
          end
          best_mode_nxt = '0;
          best_dist_nxt = DIST_ONES;
          best_gap_nxt  = GAP_ONES;
          done_nxt      = 1'b0;
        end
        KIND_EXACT: begin
          if (!done_r) begin
            out_valid_nxt = 1'b1;
            out_mode_nxt  = s1_mode_r | LINEAR_BIT;
            out_exact_nxt = 1'b1;
            done_nxt      = 1'b1;
          end
        end
        KIND_CAND: begin
          if (!done_r && ((cand_dist < best_dist_r)
              || (cand_dist == best_dist_r && s1_gap_r < best_gap_r))) begin
            best_mode_nxt = s1_mode_r;
            best_dist_nxt = cand_dist;
            best_gap_nxt  = s1_gap_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
      best_mode_r <= '0;
      best_dist_r <= DIST_ONES;
      best_gap_r  <= GAP_ONES;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      done_r      <= done_nxt;
      best_mode_r <= best_mode_nxt;
      best_dist_r <= best_dist_nxt;
      best_gap_r  <= best_gap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mode_r  <= out_mode_nxt;
    out_exact_r <= out_exact_nxt;
    if (q_pop) begin
      s1_kind_r <= head.kind;
      s1_mode_r <= head.mode;
      s1_sqx_r  <= SQ_W'(head.dx) * SQ_W'(head.dx);
      s1_sqy_r  <= SQ_W'(head.dy) * SQ_W'(head.dy);
      s1_gap_r  <= head.gap;
    end
  end

endmodule

FILE: rtl/closest_video_mode_select_unit.sv
// An end or exact-match word passes through the queue, the square stage and the output
// register before its result word is valid. Throughput: one descriptor per cycle while the
// queue is not full; the four-entry queue absorbs stalls on the result side.
// Reset (rst_n low, synchronous): targets return to zero, the queue empties and the
// running best returns to no candidate; no clearing pass is needed.
module closest_video_mode_select_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  cvms_in_if.sink                       in_chan,
  cvms_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cvms_pkg::ADDR_W-1:0]   paddr,
  input  logic [cvms_pkg::DATA_W-1:0]   pwdata,
  output logic [cvms_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import cvms_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  logic [1:0]  reg_idx;
  logic        wr_en;
  logic        q_push, q_pop, q_empty, q_full;
  entry_t      q_entry, q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = '0;
    case (reg_idx)
      REG_TARGET_WIDTH: begin
        prdata = {{(DATA_W-RES_W){1'b0}}, cfg_r.width};
        if (wr_en) cfg_nxt.width = pwdata[RES_W-1:0];
      end
      REG_TARGET_HEIGHT: begin
        prdata = {{(DATA_W-RES_W){1'b0}}, cfg_r.height};
        if (wr_en) cfg_nxt.height = pwdata[RES_W-1:0];
      end
      REG_TARGET_DEPTH: begin
        prdata = {{(DATA_W-DEPTH_W){1'b0}}, cfg_r.depth};
        if (wr_en) cfg_nxt.depth = pwdata[DEPTH_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cvms_front u_front (
    .in_chan (in_chan),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  cvms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  cvms_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench for the closest video mode selector: directed lists, then random lists.
module tb;
  import cvms_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 180;

  typedef struct packed {
    logic                eol;
    logic                ok;
    logic [MODE_W-1:0]   num;
    logic [MODE_W-1:0]   attr;
    logic [DEPTH_W-1:0]  model;
    logic [RES_W-1:0]    w;
    logic [RES_W-1:0]    h;
    logic [DEPTH_W-1:0]  d;
  } descriptor_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              exact;
  } pick_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  cvms_in_if  in_chan ();
  cvms_out_if out_chan ();

  closest_video_mode_select_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Local copy of the targets and of the running best.
  logic [RES_W-1:0]   target_w;
  logic [RES_W-1:0]   target_h;
  logic [DEPTH_W-1:0] target_d;
  logic [MODE_W-1:0]  best_num;
  logic [DIST_W-1:0]  best_dist;
  logic [GAP_W-1:0]   best_gap;
  logic               list_closed;

  pick_t expected_picks[$];
  int    errors;
  int    src_idle;
  int    sink_idle;
  int    quiet_cycles;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= sink_idle);
  end

  task automatic clear_search();
    best_num    = '0;
    best_dist   = DIST_ONES;
    best_gap    = GAP_ONES;
    list_closed = 1'b0;
  endtask

  task automatic select_mode_step(input descriptor_t dsc);
    logic [RES_W-1:0]  dx;
    logic [RES_W-1:0]  dy;
    logic [DIST_W-1:0] cand_dist;
    logic [GAP_W-1:0]  gap;
    pick_t             pick;
    if (dsc.eol) begin
      if (!list_closed) begin
        pick.mode  = (best_num != '0) ? (best_num | LINEAR_BIT) : '0;
        pick.exact = 1'b0;
        expected_picks.push_back(pick);
      end
      clear_search();
    end else if (!list_closed && dsc.ok && ((dsc.attr & ATTR_NEEDED) == ATTR_NEEDED) &&
                 (dsc.model == MODEL_PACKED || dsc.model == MODEL_DIRECT)) begin
      if (dsc.w == target_w && dsc.h == target_h && dsc.d == target_d) begin
        pick.mode   = dsc.num | LINEAR_BIT;
        pick.exact  = 1'b1;
        expected_picks.push_back(pick);
        list_closed = 1'b1;
      end else if (dsc.w <= target_w && dsc.h <= target_h) begin
        dx        = target_w - dsc.w;
        dy        = target_h - dsc.h;
        cand_dist = DIST_W'(dx) * DIST_W'(dx) + DIST_W'(dy) * DIST_W'(dy);
        gap       = GAP_W'(target_d) - GAP_W'(dsc.d);
        if (cand_dist < best_dist || (cand_dist == best_dist && gap < best_gap)) begin
          best_dist = cand_dist;
          best_gap  = gap;
          best_num  = dsc.num;
        end
      end
    end
  endtask

  // Checks the result word first, then predicts from the descriptor word of the same edge.
  always @(posedge clk) begin
    descriptor_t seen;
    pick_t       want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_picks.size() == 0) begin
        $display("%0t: unexpected result mode %h exact %b", $time,
                 out_chan.chosen_mode, out_chan.exact_hit);
        errors++;
      end else begin
        want = expected_picks.pop_front();
        if (out_chan.chosen_mode !== want.mode) begin
          $display("%0t: chosen_mode expected %h got %h", $time, want.mode,
                   out_chan.chosen_mode);
          errors++;
        end
        if (out_chan.exact_hit !== want.exact) begin
          $display("%0t: exact_hit expected %b got %b", $time, want.exact,
                   out_chan.exact_hit);
          errors++;
        end
      end
    end
    if (rst_n && in_chan.valid && in_chan.ready) begin
      seen.eol   = in_chan.end_of_list;
      seen.ok    = in_chan.info_ok;
      seen.num   = in_chan.mode_number;
      seen.attr  = in_chan.mode_attributes;
      seen.model = in_chan.memory_model;
      seen.w     = in_chan.mode_width;
      seen.h     = in_chan.mode_height;
      seen.d     = in_chan.mode_depth;
      select_mode_step(seen);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input descriptor_t dsc);
    while ($urandom_range(99) < src_idle) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.end_of_list     <= dsc.eol;
    in_chan.info_ok         <= dsc.ok;
    in_chan.mode_number     <= dsc.num;
    in_chan.mode_attributes <= dsc.attr;
    in_chan.memory_model    <= dsc.model;
    in_chan.mode_width      <= dsc.w;
    in_chan.mode_height     <= dsc.h;
    in_chan.mode_depth      <= dsc.d;
    in_chan.valid           <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Drops valid and waits until every expected result has come and the pipe has emptied.
  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    wait_drained();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TARGET_WIDTH:  target_w = value[RES_W-1:0];
      REG_TARGET_HEIGHT: target_h = value[RES_W-1:0];
      REG_TARGET_DEPTH:  target_d = value[DEPTH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_targets(input logic [RES_W-1:0] w, input logic [RES_W-1:0] h,
                             input logic [DEPTH_W-1:0] d);
    write_reg(REG_TARGET_WIDTH, DATA_W'(w));
    write_reg(REG_TARGET_HEIGHT, DATA_W'(h));
    write_reg(REG_TARGET_DEPTH, DATA_W'(d));
  endtask

  function automatic descriptor_t usable_mode(input logic [MODE_W-1:0] num,
                                              input logic [RES_W-1:0] w,
                                              input logic [RES_W-1:0] h,
                                              input logic [DEPTH_W-1:0] d);
    descriptor_t dsc;
    dsc.eol   = 1'b0;
    dsc.ok    = 1'b1;
    dsc.num   = num;
    dsc.attr  = MODE_W'($urandom) | ATTR_NEEDED;
    dsc.model = $urandom_range(1) ? MODEL_DIRECT : MODEL_PACKED;
    dsc.w     = w;
    dsc.h     = h;
    dsc.d     = d;
    return dsc;
  endfunction

  // The end word carries random content in the fields it does not use.
  function automatic descriptor_t end_word();
    descriptor_t dsc;
    dsc     = descriptor_t'({$urandom, $urandom, $urandom});
    dsc.eol = 1'b1;
    return dsc;
  endfunction

  function automatic logic [RES_W-1:0] shrink(input logic [RES_W-1:0] t);
    int span;
    case ($urandom_range(2))
      0:       span = 3;
      1:       span = 100;
      default: span = 65535;
    endcase
    if (span > int'(t)) span = int'(t);
    return t - RES_W'($urandom_range(span, 0));
  endfunction

  task automatic test_filtering();
    descriptor_t dsc;
    set_targets(16'd640, 16'd480, 8'd32);
    send_word(usable_mode(16'h0101, 16'd640, 16'd400, 8'd16));
    dsc    = usable_mode(16'h0102, 16'd640, 16'd480, 8'd32);
    dsc.ok = 1'b0;
    send_word(dsc);
    // Each of the four needed attribute bits missing on its own.
    for (int i = 0; i < MODE_W; i++) begin
      if (ATTR_NEEDED[i]) begin
        dsc      = usable_mode(16'h0103, 16'd640, 16'd480, 8'd32);
        dsc.attr = ~ATTR_NEEDED | (ATTR_NEEDED & ~(MODE_W'(1) << i));
        send_word(dsc);
      end
    end
    dsc       = usable_mode(16'h0104, 16'd640, 16'd480, 8'd32);
    dsc.model = 8'd5;
    send_word(dsc);
    send_word(usable_mode(16'h0105, 16'd800, 16'd480, 8'd32));
    send_word(usable_mode(16'h0106, 16'd640, 16'd600, 8'd32));
    send_word(usable_mode(16'h0111, 16'd640, 16'd480, 8'd16));
    send_word(end_word());
  endtask

  task automatic test_exact_match();
    send_word(usable_mode(16'h0112, 16'd620, 16'd480, 8'd32));
    send_word(usable_mode(16'h0118, 16'd640, 16'd480, 8'd32));
    send_word(usable_mode(16'h0120, 16'd640, 16'd480, 8'd32));
    send_word(end_word());
    // Hold the sender until the exact hit has come out.
    wait_drained();
  endtask

  task automatic test_no_candidate();
    send_word(end_word());
    send_word(usable_mode(16'h0000, 16'd320, 16'd200, 8'd8));
    send_word(end_word());
    send_word(usable_mode(16'hFFFF, 16'd320, 16'd200, 8'd8));
    send_word(end_word());
  endtask

  task automatic test_extremes();
    set_targets(16'h0000, 16'h0000, 8'h00);
    send_word(usable_mode(16'h0000, 16'h0000, 16'h0000, 8'h00));
    send_word(end_word());
    set_targets(16'hFFFF, 16'hFFFF, 8'hFF);
    send_word(usable_mode(16'h0ABC, 16'h0000, 16'h0000, 8'hFF));
    send_word(usable_mode(16'h0ABD, 16'h0000, 16'h0000, 8'h00));
    send_word(end_word());
    // Equal distance and gap: the earlier mode stays.
    send_word(usable_mode(16'h0001, 16'hFFFE, 16'hFFFF, 8'h10));
    send_word(usable_mode(16'h0002, 16'hFFFF, 16'hFFFE, 8'h10));
    send_word(end_word());
    // Depth above the target wraps to a large gap.
    write_reg(REG_TARGET_DEPTH, DATA_W'(8'd8));
    send_word(usable_mode(16'h0003, 16'h0010, 16'h0010, 8'd32));
    send_word(usable_mode(16'h0004, 16'h0010, 16'h0010, 8'd16));
    send_word(end_word());
  endtask

  task automatic pick_random_targets();
    case ($urandom_range(5))
      0:       set_targets(16'h0000, 16'h0000, 8'h00);
      1:       set_targets(16'hFFFF, 16'hFFFF, 8'hFF);
      2, 3:    set_targets(RES_W'($urandom_range(2048, 1)), RES_W'($urandom_range(2048, 1)),
                           DEPTH_W'($urandom_range(32, 1)));
      default: set_targets(RES_W'($urandom), RES_W'($urandom), DEPTH_W'($urandom));
    endcase
  endtask

  function automatic descriptor_t random_descriptor(output bit counted);
    descriptor_t dsc;
    int          r;
    int          bit_pick;
    r       = $urandom_range(99);
    counted = 1'b1;
    if (r < 6) begin
      dsc     = descriptor_t'({$urandom, $urandom, $urandom});
      counted = 1'b0;
    end else if (r < 14) begin
      dsc = usable_mode(MODE_W'($urandom), target_w, target_h, target_d);
    end else if (r < 22) begin
      dsc = usable_mode(MODE_W'($urandom), target_w, target_h, DEPTH_W'($urandom));
      if (target_w != 16'hFFFF && $urandom_range(1)) begin
        dsc.w = target_w + RES_W'($urandom_range(65535 - int'(target_w), 1));
      end else if (target_h != 16'hFFFF) begin
        dsc.h = target_h + RES_W'($urandom_range(65535 - int'(target_h), 1));
      end
    end else if (r < 32) begin
      dsc     = usable_mode(MODE_W'($urandom), target_w, target_h, target_d);
      counted = 1'b0;
      case ($urandom_range(2))
        0: dsc.ok = 1'b0;
        1: begin
          bit_pick = $urandom_range(3);
          dsc.attr[(bit_pick == 0) ? 0 : bit_pick + 2 + (bit_pick == 3 ? 2 : 0)] = 1'b0;
        end
        default: begin
          dsc.model = DEPTH_W'($urandom);
          if (dsc.model == MODEL_PACKED || dsc.model == MODEL_DIRECT) dsc.model = 8'd5;
        end
      endcase
    end else begin
      dsc = usable_mode(MODE_W'($urandom), shrink(target_w), shrink(target_h),
                        $urandom_range(3) == 0 ? target_d : DEPTH_W'($urandom));
    end
    return dsc;
  endfunction

  task automatic test_random_lists(input int src_pct, input int sink_pct);
    int          sent;
    int          len;
    bit          counted;
    descriptor_t dsc;
    src_idle  = src_pct;
    sink_idle = sink_pct;
    sent      = 0;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(2) == 0) pick_random_targets();
      len = $urandom_range(16, 1);
      for (int i = 0; i < len; i++) begin
        if (i == len / 2 && $urandom_range(9) == 0) begin
          write_reg(2'($urandom_range(2)), $urandom);
        end
        dsc = random_descriptor(counted);
        send_word(dsc);
        if (counted) sent++;
      end
      send_word(end_word());
      sent++;
      if ($urandom_range(5) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n                   = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    in_chan.valid           = 1'b0;
    in_chan.end_of_list     = 1'b0;
    in_chan.info_ok         = 1'b0;
    in_chan.mode_number     = '0;
    in_chan.mode_attributes = '0;
    in_chan.memory_model    = '0;
    in_chan.mode_width      = '0;
    in_chan.mode_height     = '0;
    in_chan.mode_depth      = '0;
    out_chan.ready          = 1'b0;
    errors                  = 0;
    quiet_cycles            = 0;
    src_idle                = 15;
    sink_idle               = 73;
    target_w                = '0;
    target_h                = '0;
    target_d                = '0;
    clear_search();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_filtering();
    test_exact_match();
    test_no_candidate();
    test_extremes();
    test_random_lists(15, 73);
    test_random_lists(73, 15);
    test_random_lists(0, 0);

    wait_drained();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
